@@ rtl/core/fbpa_pkg.sv @@
// Package for the fixed block pool allocator.
// Shared constants, status and command codes, and back-end state type.
// No dependencies.
`default_nettype none

package fbpa_pkg;

  localparam int ADDR_W         = 32;
  localparam int STATUS_W       = 3;
  localparam int COUNT_OUT_W    = 6;
  localparam int BLK_COUNT_DEF  = 32;
  localparam int BLOCK_BYTES    = 128;
  localparam int HEADER_BYTES   = 16;
  localparam int BLK_SHIFT      = $clog2(BLOCK_BYTES);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic OP_REQ = 1'b0;
  localparam logic OP_REL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_NULL   = 3'd2,
    ST_BOUNDS = 3'd3,
    ST_ALIGN  = 3'd4,
    ST_FREE   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_REQ = 2'd0,
    CMD_REL = 2'd1,
    CMD_REJ = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    status_t   status;
  } cmd_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RD   = 1'b1
  } bk_state_t;

endpackage

`default_nettype wire

@@ rtl/core/fbpa_front.sv @@
// Front end of the allocator: accepts items and classifies releases.
// Runs the null, bounds and alignment checks. Depends on fbpa_pkg.
`default_nettype none

module fbpa_front #(
  parameter int BLK_COUNT = fbpa_pkg::BLK_COUNT_DEF,
  parameter int IDX_W     = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1
) (
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_op,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] in_block_addr,
  input  wire logic [fbpa_pkg::ADDR_W:0]   base_hdr,
  input  wire logic                        q_full,
  output logic                             q_push,
  output fbpa_pkg::cmd_t                   q_cmd,
  output logic [IDX_W-1:0]                 q_idx
);
  import fbpa_pkg::*;

  localparam logic [ADDR_W:0] POOL_BYTES = (ADDR_W+1)'(BLK_COUNT * BLOCK_BYTES);

  logic [ADDR_W+1:0] off;
  logic              below;
  logic              in_range;
  logic              aligned;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign off      = {2'b00, in_block_addr} - {1'b0, base_hdr};
  assign below    = off[ADDR_W+1];
  assign in_range = !below && (off[ADDR_W:0] < POOL_BYTES);
  assign aligned  = (off[BLK_SHIFT-1:0] == '0);
  assign q_idx    = off[BLK_SHIFT +: IDX_W];

  always_comb begin
    q_cmd.kind   = CMD_REQ;
    q_cmd.status = ST_OK;
    if (in_op == OP_REL) begin
      if (in_block_addr == '0) begin
        q_cmd.kind   = CMD_REJ;
        q_cmd.status = ST_NULL;
      end else if (!in_range) begin
        q_cmd.kind   = CMD_REJ;
        q_cmd.status = ST_BOUNDS;
      end else if (!aligned) begin
        q_cmd.kind   = CMD_REJ;
        q_cmd.status = ST_ALIGN;
      end else begin
        q_cmd.kind   = CMD_REL;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fbpa_queue.sv @@
// Small register queue between the front and back ends.
// Generic width and depth. Depends on fbpa_pkg for the default depth.
`default_nettype none

module fbpa_queue #(
  parameter int W     = 8,
  parameter int DEPTH = fbpa_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              pop_valid,
  output logic [W-1:0]      pop_data
);
  import fbpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fbpa_back.sv @@
// Back end of the allocator: free-index stack memory, free bitmap,
// free count and the result register. Depends on fbpa_pkg.
`default_nettype none

module fbpa_back #(
  parameter int BLK_COUNT = fbpa_pkg::BLK_COUNT_DEF,
  parameter int IDX_W     = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire fbpa_pkg::cmd_t                   q_cmd,
  input  wire logic [IDX_W-1:0]                 q_idx,
  output logic                                  q_pop,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]      base_hdr,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [fbpa_pkg::STATUS_W-1:0]         out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]           out_grant_addr,
  output logic [fbpa_pkg::COUNT_OUT_W-1:0]      out_free_count
);
  import fbpa_pkg::*;

  localparam int CNT_W = $clog2(BLK_COUNT + 1);

  bk_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  lwm_r, lwm_nxt;
  logic [BLK_COUNT-1:0] map_r, map_nxt;
  logic              init_r, init_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;

  logic [IDX_W-1:0]  stack_mem [BLK_COUNT];
  logic [IDX_W-1:0]  rd_data_r;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  wr_pos, rd_pos;

  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  grant_idx;
  logic              slot_free;
  logic              load;
  status_t           ld_status;
  logic [ADDR_W-1:0] ld_grant;
  logic [CNT_W-1:0]  ld_count;

  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r;
  logic [ADDR_W-1:0]      out_grant_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  assign cnt_m1    = count_r - CNT_W'(1);
  assign wr_pos    = count_r[IDX_W-1:0];
  assign rd_pos    = cnt_m1[IDX_W-1:0];
  assign grant_idx = init_r ? pos_r : rd_data_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lwm_nxt   = lwm_r;
    map_nxt   = map_r;
    init_nxt  = init_r;
    pos_nxt   = pos_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    q_pop     = 1'b0;
    load      = 1'b0;
    ld_status = ST_OK;
    ld_grant  = '0;
    ld_count  = count_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_REQ: begin
              if (count_r == '0) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                count_nxt = cnt_m1;
                pos_nxt   = rd_pos;
                init_nxt  = (cnt_m1 < lwm_r);
                if (cnt_m1 < lwm_r) begin
                  lwm_nxt = cnt_m1;
                end
                state_nxt = BK_RD;
              end
            end
            CMD_REL: begin
              load = 1'b1;
              if (map_r[q_idx] || (count_r >= CNT_W'(BLK_COUNT))) begin
                ld_status = ST_FREE;
              end else begin
                mem_we         = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
                ld_count       = count_r + CNT_W'(1);
                map_nxt[q_idx] = 1'b1;
              end
            end
            default: begin
              load      = 1'b1;
              ld_status = q_cmd.status;
            end
          endcase
        end
      end
      BK_RD: begin
        load               = 1'b1;
        map_nxt[grant_idx] = 1'b0;
        ld_grant           = base_hdr + (ADDR_W'(grant_idx) << BLK_SHIFT);
        state_nxt          = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= CNT_W'(BLK_COUNT);
      lwm_r       <= CNT_W'(BLK_COUNT);
      map_r       <= '1;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lwm_r       <= lwm_nxt;
      map_r       <= map_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (load) begin
      out_status_r <= ld_status;
      out_grant_r  <= ld_grant;
      out_count_r  <= COUNT_OUT_W'(ld_count);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_pos] <= q_idx;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[rd_pos];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_grant_addr = out_grant_r;
  assign out_free_count = out_count_r;

endmodule

`default_nettype wire

@@ rtl/core/fixed_block_pool_allocator_core.sv @@
// Top level of the fixed block pool allocator: heap base register,
// front end, command queue and back end. Depends on fbpa_pkg and the fbpa_* modules.
`default_nettype none

// Hands out and takes back equal blocks of a pool above heap_base. A request
// pops the top free index and returns its data address; a release is checked
// (null, bounds, alignment, already free) and pushes the index back. The front
// end takes one item per cycle while its two-entry queue has room. In the back
// end a release or rejected item goes straight to the output register, and a
// successful request first passes the registered read of the free-index stack
// memory; the result sits in an output register until taken. Never-popped stack
// entries read as their own index through a low-water mark, so there is no
// clearing pass after reset. Write heap_base only while no item is in flight.
module fixed_block_pool_allocator_core #(
  parameter int BLK_COUNT = fbpa_pkg::BLK_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]      cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_op,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]      in_block_addr,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [fbpa_pkg::STATUS_W-1:0]         out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]           out_grant_addr,
  output logic [fbpa_pkg::COUNT_OUT_W-1:0]      out_free_count
);
  import fbpa_pkg::*;

  localparam int IDX_W = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1;
  localparam int QW    = $bits(cmd_t) + IDX_W;

  logic [ADDR_W:0]  base_hdr_r;
  logic             q_full, q_push, q_pop, q_valid;
  cmd_t             f_cmd, b_cmd;
  logic [IDX_W-1:0] f_idx, b_idx;
  logic [QW-1:0]    q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_hdr_r <= (ADDR_W+1)'(HEADER_BYTES);
    end else if (cfg_wr_en) begin
      base_hdr_r <= {1'b0, cfg_wr_data} + (ADDR_W+1)'(HEADER_BYTES);
    end
  end

  fbpa_front #(
    .BLK_COUNT (BLK_COUNT),
    .IDX_W     (IDX_W)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_block_addr (in_block_addr),
    .base_hdr      (base_hdr_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (f_cmd),
    .q_idx         (f_idx)
  );

  fbpa_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_cmd, f_idx}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  assign b_cmd = q_out[QW-1:IDX_W];
  assign b_idx = q_out[IDX_W-1:0];

  fbpa_back #(
    .BLK_COUNT (BLK_COUNT),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (b_cmd),
    .q_idx          (b_idx),
    .q_pop          (q_pop),
    .base_hdr       (base_hdr_r[ADDR_W-1:0]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_grant_addr (out_grant_addr),
    .out_free_count (out_free_count)
  );

endmodule

`default_nettype wire

@@ rtl/core/fbpa_checker.sv @@
// Port-level checker for the allocator result channel, with its bind.
// Depends on fbpa_pkg and fixed_block_pool_allocator_core.
`default_nettype none

module fbpa_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [fbpa_pkg::STATUS_W-1:0]    out_status,
  input wire logic [fbpa_pkg::ADDR_W-1:0]      out_grant_addr,
  input wire logic [fbpa_pkg::COUNT_OUT_W-1:0] out_free_count
);
  import fbpa_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_grant_addr) && $stable(out_free_count))
    else $error("result changed while stalled");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_grant_addr == '0)
    else $error("grant address on a failed item");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_free_count == '0)
    else $error("empty status with free blocks left");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_grant_addr (out_grant_addr),
  .out_free_count (out_free_count)
);

`default_nettype wire
